/* rtl/fss_pkg.sv */
// Shared types and codes of the fair-share slot scheduler.
package fss_pkg;

  // Input operation codes.
  localparam logic [1:0] OP_DEMAND = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_TASK_COUNT = 2'd0;
  localparam logic [1:0] REG_CORE       = 2'd1;
  localparam logic [1:0] REG_TOLERANCE  = 2'd2;

  localparam logic [3:0] TASK_COUNT_RST = 4'd8;

  // Operand pairs of the shared multiplier.
  typedef enum logic [1:0] {
    MS_TD = 2'd0,  // elapsed * demand
    MS_CL = 2'd1,  // done * length
    MS_BD = 2'd2   // (best * 256 + tolerance) * demand
  } mul_sel_t;

  typedef struct packed {
    logic     wr_demand;
    logic     start_ivl;
    logic     scan_init;
    logic     task_next;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     div_go;
    logic     take_win;
    logic     finish;
  } fss_cmd_t;

  typedef struct packed {
    logic tick_live;
    logic scan_end;
    logic task_skip;
    logic mul_done;
    logic div_done;
    logic not_elig;
    logic over_best;
  } fss_sts_t;

  typedef struct packed {
    logic        granted;
    logic [2:0]  task_id;
    logic [31:0] slot_time;
    logic        last;
    logic        short_fall;
  } fss_res_t;

endpackage

/* rtl/fss_ctrl.sv */
// Controller state machine that sequences one slot decision over the task list.
module fss_ctrl import fss_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  input  logic       out_free,
  input  fss_sts_t   sts,
  output logic       in_ready,
  output fss_cmd_t   cmd
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_CHK  = 7'b0000010,
    ST_M1   = 7'b0000100,
    ST_M2   = 7'b0001000,
    ST_M3   = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_END  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   acc;

  assign in_ready = (state_r == ST_IDLE);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MS_TD;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          cmd.wr_demand = (in_op == OP_DEMAND);
          cmd.start_ivl = (in_op == OP_START);
          if (in_op == OP_TICK && sts.tick_live) begin
            cmd.scan_init = 1'b1;
            state_nxt     = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        if (sts.scan_end) begin
          state_nxt = ST_END;
        end else if (sts.task_skip) begin
          cmd.task_next = 1'b1;
        end else begin
          cmd.mul_go  = 1'b1;
          cmd.mul_sel = MS_TD;
          state_nxt   = ST_M1;
        end
      end
      ST_M1: begin
        if (sts.mul_done) begin
          cmd.mul_go  = 1'b1;
          cmd.mul_sel = MS_CL;
          state_nxt   = ST_M2;
        end
      end
      ST_M2: begin
        if (sts.mul_done) begin
          if (sts.not_elig) begin
            cmd.task_next = 1'b1;
            state_nxt     = ST_CHK;
          end else begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MS_BD;
            state_nxt   = ST_M3;
          end
        end
      end
      ST_M3: begin
        if (sts.mul_done) begin
          if (sts.over_best) begin
            cmd.task_next = 1'b1;
            state_nxt     = ST_CHK;
          end else begin
            cmd.div_go = 1'b1;
            state_nxt  = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.take_win  = 1'b1;
          cmd.task_next = 1'b1;
          state_nxt     = ST_CHK;
        end
      end
      ST_END: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/fss_dp.sv */
// Datapath: task tables, interval state, shared serial multiplier and divider.
module fss_dp import fss_pkg::*; #(
  parameter int MAX_TASKS = 8,
  parameter int LEN_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  fss_cmd_t    cmd,
  input  logic [2:0]  task_index,
  input  logic [15:0] amount,
  input  logic [31:0] start_time,
  input  logic [3:0]  task_count,
  input  logic [7:0]  tie_tolerance,
  output fss_sts_t    sts,
  output fss_res_t    res
);

  localparam int L   = LEN_BITS;
  localparam int XW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int IW  = $clog2(MAX_TASKS + 1);
  localparam int BW  = L + 9;
  localparam int PW  = 2 * L + 9;
  localparam int DW  = 2 * L + 2;
  localparam int MCW = $clog2(L);
  localparam int DCW = $clog2(DW);

  logic [L-1:0]  demand_r [MAX_TASKS];
  logic [L-1:0]  done_r   [MAX_TASKS];
  logic [L-1:0]  len_r, t_r, amt;
  logic [31:0]   base_r;
  logic [IW-1:0] i_r, n_cur;
  logic [XW-1:0] ix, win_ix_r;
  logic          win_vld_r;
  logic [L:0]    best_r;
  logic [L-1:0]  d_cur, c_cur, t_nxt;
  logic [2*L-1:0] p1_r, p2_r, p2_now, fsum;

  // Serial multiplier.
  logic [PW-1:0]  ma_r, macc_r;
  logic [L-1:0]   mb_r;
  logic [MCW-1:0] mcnt_r;
  logic           mbusy_r, mdone_r;
  mul_sel_t       msel_r;
  logic [BW-1:0]  ma_in;
  logic [L-1:0]   mb_in;

  // Restoring divider, one quotient bit per cycle.
  logic [DW-1:0]  dvd_r, q_r, dvd_in;
  logic [L:0]     rem_r, dsr_r;
  logic [L+1:0]   rtry;
  logic [DCW-1:0] dcnt_r;
  logic           dbusy_r, ddone_r;

  logic [2*L+1:0] e_lhs, e_rhs;
  logic [PW-1:0]  f_lhs;
  logic           shortfall;

  assign amt    = L'(amount);
  assign n_cur  = (int'(task_count) > MAX_TASKS) ? IW'(MAX_TASKS) : IW'(task_count);
  assign ix     = i_r[XW-1:0];
  assign d_cur  = demand_r[ix];
  assign c_cur  = done_r[ix];
  assign p2_now = macc_r[2*L-1:0];
  assign fsum   = p2_r + (2*L)'(len_r);

  always_comb begin
    case (cmd.mul_sel)
      MS_TD: begin
        ma_in = BW'(t_r);
        mb_in = d_cur;
      end
      MS_CL: begin
        ma_in = BW'(c_cur);
        mb_in = len_r;
      end
      MS_BD: begin
        ma_in = {best_r, tie_tolerance};
        mb_in = d_cur;
      end
      default: begin
        ma_in = '0;
        mb_in = '0;
      end
    endcase
  end

  // Task is late enough when c <= round(t*d/len), i.e. not 2*t*d + len < 2*c*len.
  assign e_lhs = (2*L+2)'({p1_r, 1'b0}) + (2*L+2)'(len_r);
  assign e_rhs = (2*L+2)'({p2_now, 1'b0});
  // Finish time (c+1)*len/d against best + tolerance/256, scaled by 256*d.
  assign f_lhs = PW'({fsum, 8'd0});
  assign dvd_in = DW'({fsum, 1'b0}) + DW'(d_cur);
  assign rtry   = {rem_r, dvd_r[DW-1]};

  assign sts.tick_live = (t_r < len_r);
  assign sts.scan_end  = (i_r == n_cur);
  assign sts.task_skip = (d_cur == '0) || (c_cur >= d_cur);
  assign sts.mul_done  = mdone_r;
  assign sts.div_done  = ddone_r;
  assign sts.not_elig  = (e_lhs < e_rhs);
  assign sts.over_best = (f_lhs > macc_r);

  assign t_nxt = (t_r + L'(1) == '0) ? len_r : t_r + L'(1);

  always_comb begin
    shortfall = 1'b0;
    for (int k = 0; k < MAX_TASKS; k++) begin
      if (k < int'(n_cur)) begin
        if (done_r[k] + L'(win_vld_r && (win_ix_r == XW'(k))) < demand_r[k]) begin
          shortfall = 1'b1;
        end
      end
    end
  end

  assign res.granted    = win_vld_r;
  assign res.task_id    = win_vld_r ? 3'(win_ix_r) : 3'd0;
  assign res.slot_time  = base_r + 32'(t_r);
  assign res.last       = (t_r + L'(1) == len_r);
  assign res.short_fall = res.last && shortfall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_TASKS; k++) begin
        demand_r[k] <= '0;
        done_r[k]   <= '0;
      end
      len_r     <= '0;
      base_r    <= '0;
      t_r       <= '0;
      i_r       <= '0;
      win_vld_r <= 1'b0;
      mbusy_r   <= 1'b0;
      mdone_r   <= 1'b0;
      dbusy_r   <= 1'b0;
      ddone_r   <= 1'b0;
    end else begin
      if (cmd.wr_demand && int'(task_index) < MAX_TASKS) begin
        demand_r[XW'(task_index)] <= amt;
      end
      if (cmd.start_ivl) begin
        for (int k = 0; k < MAX_TASKS; k++) done_r[k] <= '0;
        len_r  <= amt;
        base_r <= start_time;
        t_r    <= '0;
      end
      if (cmd.scan_init) begin
        i_r       <= '0;
        win_vld_r <= 1'b0;
      end
      if (cmd.task_next) i_r <= i_r + IW'(1);
      if (cmd.take_win) begin
        win_vld_r <= 1'b1;
      end
      if (cmd.finish) begin
        if (win_vld_r) done_r[win_ix_r] <= done_r[win_ix_r] + L'(1);
        t_r <= t_nxt;
      end

      mdone_r <= 1'b0;
      if (cmd.mul_go) begin
        mbusy_r <= 1'b1;
        mcnt_r  <= '0;
      end else if (mbusy_r) begin
        mcnt_r <= mcnt_r + MCW'(1);
        if (mcnt_r == MCW'(L - 1)) begin
          mbusy_r <= 1'b0;
          mdone_r <= 1'b1;
        end
      end

      ddone_r <= 1'b0;
      if (cmd.div_go) begin
        dbusy_r <= 1'b1;
        dcnt_r  <= '0;
      end else if (dbusy_r) begin
        dcnt_r <= dcnt_r + DCW'(1);
        if (dcnt_r == DCW'(DW - 1)) begin
          dbusy_r <= 1'b0;
          ddone_r <= 1'b1;
        end
      end
    end
  end

  // Payload of the scan and the arithmetic units.
  always_ff @(posedge clk) begin
    if (cmd.scan_init) best_r <= (L+1)'(len_r) + (L+1)'(1);
    if (cmd.take_win) begin
      best_r   <= q_r[L:0];
      win_ix_r <= ix;
    end
    if (mdone_r && msel_r == MS_TD) p1_r <= p2_now;
    if (mdone_r && msel_r == MS_CL) p2_r <= p2_now;

    if (cmd.mul_go) begin
      ma_r   <= PW'(ma_in);
      mb_r   <= mb_in;
      macc_r <= '0;
      msel_r <= cmd.mul_sel;
    end else if (mbusy_r) begin
      if (mb_r[0]) macc_r <= macc_r + ma_r;
      ma_r <= {ma_r[PW-2:0], 1'b0};
      mb_r <= mb_r >> 1;
    end

    if (cmd.div_go) begin
      dvd_r <= dvd_in;
      dsr_r <= {d_cur, 1'b0};
      rem_r <= '0;
      q_r   <= '0;
    end else if (dbusy_r) begin
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      if (rtry >= (L+2)'(dsr_r)) begin
        rem_r <= (L+1)'(rtry - (L+2)'(dsr_r));
        q_r   <= {q_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= rtry[L:0];
        q_r   <= {q_r[DW-2:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/fair_share_slot_scheduler.sv */
// Top level of the fair-share slot scheduler: register port, output register, core.
// Software loads each task's slot demand (operation 0), then opens an interval with
// a length and an absolute start time (operation 1), which clears all done counts.
// Each slot tick (operation 2) inside an interval produces exactly one result beat:
// the tasks below task_count are scanned in order, a task being eligible when its
// done count is at most round(elapsed*demand/length) and below its demand; the last
// eligible task whose finish time (done+1)*length/demand is within the running best
// (rounded half up) plus tie_tolerance/256 gets the slot. Idle slots still report a
// beat with granted low, and the last slot of the interval raises tlast and flags a
// shortfall if any scanned task ended below its demand. Demand and start beats, ticks
// outside an interval and operation 3 give no result. One item is worked on at a time.
// A demand or start beat is taken in the idle state and writes its tables directly.
// A tick visits each scanned task in a check state: a task with zero or met demand
// is skipped there, the others pass through the shared serial multiplier (up to three
// products per task) and the restoring divider (only for a task whose finish time is
// within the best so far plus the tolerance) before the next task. A new beat is
// taken while the previous result still waits in the output register.
module fair_share_slot_scheduler import fss_pkg::*; #(
  parameter int MAX_TASKS = 8,
  parameter int LEN_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] operation, [4:2] task_index, [20:5] amount, [52:21] start_time
  input  logic [55:0] in_tdata,
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] granted, [3:1] task_id, [35:4] slot_time, [43:36] core_out, [44] shortfall
  output logic [47:0] out_tdata,
  output logic        out_tlast,  // interval_done
  // Register port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [3:0]  task_count_r;
  logic [7:0]  core_r, tol_r;
  logic        cfg_wr;
  logic        out_vld_r, out_free;
  logic [47:0] out_data_r;
  logic        out_last_r;
  fss_cmd_t    cmd;
  fss_sts_t    sts;
  fss_res_t    res;

  // Register file. Writes land on the access phase of a write transfer.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r <= TASK_COUNT_RST;
      core_r       <= '0;
      tol_r        <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_TASK_COUNT: task_count_r <= cfg_pwdata[3:0];
        REG_CORE:       core_r       <= cfg_pwdata[7:0];
        REG_TOLERANCE:  tol_r        <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_TASK_COUNT: cfg_prdata = {28'd0, task_count_r};
      REG_CORE:       cfg_prdata = {24'd0, core_r};
      REG_TOLERANCE:  cfg_prdata = {24'd0, tol_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // The result register frees up in the same cycle its beat is taken.
  assign out_free = !out_vld_r || out_tready;

  fss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tdata[1:0]),
    .out_free (out_free),
    .sts      (sts),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  fss_dp #(
    .MAX_TASKS (MAX_TASKS),
    .LEN_BITS  (LEN_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .task_index    (in_tdata[4:2]),
    .amount        (in_tdata[20:5]),
    .start_time    (in_tdata[52:21]),
    .task_count    (task_count_r),
    .tie_tolerance (tol_r),
    .sts           (sts),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.finish) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= {3'd0, res.short_fall, core_r, res.slot_time, res.task_id, res.granted};
      out_last_r <= res.last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

/* rtl/fss_chk.sv */
// Port-level checker for the fair-share slot scheduler, bound to the top level.
module fss_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tlast
);

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // Shortfall is reported only on the last slot of an interval.
  a_short_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !out_tdata[44])
    else $error("shortfall outside the last slot");

  // An idle slot names no task.
  a_idle_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[3:1] == 3'd0)
    else $error("idle slot carries a task id");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind fair_share_slot_scheduler fss_chk u_fss_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
